[hdl/modbus_rtu_frame_receiver_defines.svh]
// Assertion macros shared by the receiver's checker.
`ifndef MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_FRAME_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define MRFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("receiver check failed");

`endif

[hdl/mrfr_pkg.sv]
// Types, codes and the CRC16 byte update shared by the frame receiver.
package mrfr_pkg;

	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_BYTE    = 2'd1;
	localparam logic [1:0] EV_VERDICT = 2'd2;

	localparam logic [2:0] VERDICT_ACCEPTED  = 3'd0;
	localparam logic [2:0] VERDICT_BROADCAST = 3'd1;
	localparam logic [2:0] VERDICT_OVERRUN   = 3'd2;
	localparam logic [2:0] VERDICT_SHORT     = 3'd3;
	localparam logic [2:0] VERDICT_FOREIGN   = 3'd4;
	localparam logic [2:0] VERDICT_CRC_BAD   = 3'd5;

	localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
	localparam logic [1:0] CFG_SILENCE_TICKS  = 2'd1;
	localparam logic [1:0] CFG_RTS_HIGH_LIMIT = 2'd2;

	localparam logic [7:0]  OWN_ADDRESS_RESET    = 8'd1;
	localparam logic [15:0] SILENCE_TICKS_RESET  = 16'd4;
	localparam logic [15:0] RTS_HIGH_LIMIT_RESET = 16'd500;

	localparam logic [7:0]  BROADCAST_ADDRESS = 8'h00;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam int unsigned MIN_FRAME_BYTES = 4;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_BYTE,
		KIND_TICK,
		KIND_RELEASE
	} kind_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] rx_byte;
		logic       rts_is_high;
	} in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		logic [2:0] verdict;
		logic [8:0] frame_length;
		logic [7:0] function_code;
		logic       force_rts_low;
	} out_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] rx_byte;
		logic       rts_is_high;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic [15:0] data;
	} cfg_wr_t;

	// Reflected CRC16 update over one byte, least significant bit first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hdl/modbus_rtu_frame_receiver.sv]
// With no backlog, an accepted input is registered in the queue, then its result in the output register.
// Throughput: one input transaction per cycle unless in_stall; every input yields exactly one result.
// The front end feeds a two-entry queue; the frame engine drains one entry per cycle into an output
// register unless out_stall holds it, so input stalls only when the queue fills under output stall.
// Reset (arst_n low, asynchronous) empties the queue and the output register and loads
// the frame state and the register defaults: address 1, silence 4 ticks, RTS limit 500.
module modbus_rtu_frame_receiver #(
	parameter int unsigned BUFFER_BYTES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mrfr_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output mrfr_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import mrfr_pkg::*;

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_not_empty;
	item_t   q_item;
	item_t   q_head;
	cfg_wr_t cfg_wr;

	// Registers are plain flops, so a write is always taken.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	mrfr_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	mrfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mrfr_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.cfg_wr      (cfg_wr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

[hdl/mrfr_front.sv]
// Front end: accepts input transactions and classifies the command.
module mrfr_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  mrfr_pkg::in_t in_data,
	input  logic          q_full,
	output logic          q_push,
	output mrfr_pkg::item_t q_item
);
	import mrfr_pkg::*;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item.rx_byte     = in_data.rx_byte;
		q_item.rts_is_high = in_data.rts_is_high;
		unique case (in_data.cmd)
			CMD_BYTE:    q_item.kind = KIND_BYTE;
			CMD_TICK:    q_item.kind = KIND_TICK;
			CMD_RELEASE: q_item.kind = KIND_RELEASE;
			default:     q_item.kind = KIND_NONE;
		endcase
	end

endmodule

[hdl/mrfr_queue.sv]
// Short FIFO between the front end and the frame engine.
module mrfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mrfr_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output mrfr_pkg::item_t head
);
	import mrfr_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slots_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[hdl/mrfr_back.sv]
// Frame engine: byte buffer count, CRC, silence timer, verdict and RTS watchdog.
module mrfr_back #(
	parameter int unsigned BUFFER_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  mrfr_pkg::item_t   q_head,
	output logic              q_pop,
	input  mrfr_pkg::cfg_wr_t cfg_wr,
	output logic              out_valid,
	input  logic              out_stall,
	output mrfr_pkg::out_t    out_data
);
	import mrfr_pkg::*;

	localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0]   quiet_q, quiet_d;
	logic          held_q, held_d;
	logic          ovr_q, ovr_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    tail0_q, tail0_d;
	logic [7:0]    tail1_q, tail1_d;
	logic [7:0]    first_q, first_d;
	logic [7:0]    second_q, second_d;
	logic [15:0]   rtsc_q, rtsc_d;

	logic [7:0]    own_addr_q;
	logic [15:0]   silence_q;
	logic [15:0]   rts_limit_q;

	logic          out_valid_q;
	out_t          out_q;
	out_t          res;

	logic [CW+7:0] idx_ext;
	logic [CW+8:0] len_ext;
	logic [15:0]   quiet_inc;
	logic [15:0]   rtsc_inc;
	logic [2:0]    judged;

	assign q_pop     = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign idx_ext   = {8'h00, cnt_q};
	assign len_ext   = {9'h000, cnt_q};
	assign quiet_inc = (quiet_q == COUNT_MAX) ? quiet_q : quiet_q + 16'd1;
	assign rtsc_inc  = (rtsc_q == COUNT_MAX) ? rtsc_q : rtsc_q + 16'd1;

	// Checks are ordered: overrun, short, foreign address, CRC, broadcast.
	always_comb begin
		if (ovr_q) begin
			judged = VERDICT_OVERRUN;
		end else if (cnt_q < CW'(MIN_FRAME_BYTES)) begin
			judged = VERDICT_SHORT;
		end else if (first_q != own_addr_q && first_q != BROADCAST_ADDRESS) begin
			judged = VERDICT_FOREIGN;
		end else if ({tail1_q, tail0_q} != crc_q) begin
			judged = VERDICT_CRC_BAD;
		end else if (first_q == BROADCAST_ADDRESS) begin
			judged = VERDICT_BROADCAST;
		end else begin
			judged = VERDICT_ACCEPTED;
		end
	end

	always_comb begin
		cnt_d    = cnt_q;
		quiet_d  = quiet_q;
		held_d   = held_q;
		ovr_d    = ovr_q;
		crc_d    = crc_q;
		tail0_d  = tail0_q;
		tail1_d  = tail1_q;
		first_d  = first_q;
		second_d = second_q;
		rtsc_d   = rtsc_q;
		res      = '0;
		unique case (q_head.kind)
			KIND_BYTE: begin
				if (!held_q) begin
					if (cnt_q < CW'(BUFFER_BYTES)) begin
						// The two newest bytes are the received CRC and stay out of the sum.
						if (cnt_q >= CW'(2)) begin
							crc_d = crc16_byte(crc_q, tail0_q);
						end
						tail0_d = tail1_q;
						tail1_d = q_head.rx_byte;
						if (cnt_q == '0) begin
							first_d = q_head.rx_byte;
						end else if (cnt_q == CW'(1)) begin
							second_d = q_head.rx_byte;
						end
						res.event_res  = EV_BYTE;
						res.byte_index = idx_ext[7:0];
						res.byte_value = q_head.rx_byte;
						cnt_d = cnt_q + CW'(1);
					end else begin
						ovr_d = 1'b1;
					end
					quiet_d = '0;
				end
			end
			KIND_TICK: begin
				if (cnt_q != '0 && !held_q) begin
					quiet_d = quiet_inc;
					if (quiet_inc >= silence_q) begin
						held_d             = 1'b1;
						res.event_res      = EV_VERDICT;
						res.verdict        = judged;
						res.frame_length   = len_ext[8:0];
						res.function_code  = second_q;
					end
				end
				if (q_head.rts_is_high) begin
					if (rtsc_inc > rts_limit_q) begin
						res.force_rts_low = 1'b1;
						rtsc_d = '0;
					end else begin
						rtsc_d = rtsc_inc;
					end
				end else begin
					rtsc_d = '0;
				end
			end
			KIND_RELEASE: begin
				cnt_d    = '0;
				quiet_d  = '0;
				held_d   = 1'b0;
				ovr_d    = 1'b0;
				crc_d    = CRC_INIT;
				tail0_d  = '0;
				tail1_d  = '0;
				first_d  = '0;
				second_d = '0;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			quiet_q  <= '0;
			held_q   <= 1'b0;
			ovr_q    <= 1'b0;
			crc_q    <= CRC_INIT;
			tail0_q  <= '0;
			tail1_q  <= '0;
			first_q  <= '0;
			second_q <= '0;
			rtsc_q   <= '0;
		end else if (q_pop) begin
			cnt_q    <= cnt_d;
			quiet_q  <= quiet_d;
			held_q   <= held_d;
			ovr_q    <= ovr_d;
			crc_q    <= crc_d;
			tail0_q  <= tail0_d;
			tail1_q  <= tail1_d;
			first_q  <= first_d;
			second_q <= second_d;
			rtsc_q   <= rtsc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q  <= OWN_ADDRESS_RESET;
			silence_q   <= SILENCE_TICKS_RESET;
			rts_limit_q <= RTS_HIGH_LIMIT_RESET;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				CFG_OWN_ADDRESS:    own_addr_q  <= cfg_wr.data[7:0];
				CFG_SILENCE_TICKS:  silence_q   <= cfg_wr.data;
				CFG_RTS_HIGH_LIMIT: rts_limit_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule

[hdl/mrfr_checker.sv]
// Port-level checks for the frame receiver and their bind to the top level.
`include "modbus_rtu_frame_receiver_defines.svh"

module mrfr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input mrfr_pkg::out_t out_data
);
	import mrfr_pkg::*;

	logic byte_fields_zero;
	logic verdict_fields_zero;

	assign byte_fields_zero = (out_data.byte_index == 8'h00) &&
		(out_data.byte_value == 8'h00);
	assign verdict_fields_zero = (out_data.verdict == VERDICT_ACCEPTED) &&
		(out_data.frame_length == 9'h000) && (out_data.function_code == 8'h00);

	// A stalled result stays offered.
	`MRFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// Byte fields are zero on any result that is not a stored byte.
	`MRFR_ASSERT_NOW(a_byte_fields_clear, out_valid && out_data.event_res != EV_BYTE, byte_fields_zero)

	// Verdict fields are zero unless a verdict is reported, and the code is in range.
	`MRFR_ASSERT_NOW(a_verdict_fields, out_valid && out_data.event_res != EV_VERDICT, verdict_fields_zero)

	`MRFR_ASSERT_NOW(a_verdict_code, out_valid && out_data.event_res == EV_VERDICT, out_data.verdict <= VERDICT_CRC_BAD)

endmodule

bind modbus_rtu_frame_receiver mrfr_checker u_mrfr_checker (.*);
